// ===== rtl/core/scd_pkg.sv =====
// Package with command codes, response kinds and character helpers of the command decoder.
package scd_pkg;

  localparam logic [7:0] CMD_TOGGLE  = 8'h81;
  localparam logic [7:0] CMD_GET     = 8'h82;
  localparam logic [7:0] CMD_SET     = 8'h83;
  localparam logic [7:0] CMD_CLEAR   = 8'h84;
  localparam logic [7:0] ASCII_TIME  = 8'h74;
  localparam logic [7:0] ASCII_LED   = 8'h79;
  localparam logic [7:0] CHAR_CR     = 8'h0D;
  localparam logic [7:0] CHAR_LF     = 8'h0A;

  localparam logic [13:0] VALUE_RESET = 14'h3FFF;

  // Beat positions inside a time response.
  localparam logic [4:0] TIME_DIGIT_FIRST = 5'd7;
  localparam logic [4:0] TIME_DIGIT_TOP   = 5'd14;
  localparam logic [4:0] TIME_CR_IDX      = 5'd15;
  localparam logic [4:0] TIME_LAST_IDX    = 5'd16;
  localparam logic [4:0] GET_LAST_IDX     = 5'd1;

  typedef enum logic [1:0] {
    RESP_NONE,
    RESP_GET,
    RESP_TIME
  } resp_kind_e;

  // Characters of the "time=0x" prefix.
  function automatic logic [7:0] prefix_char(input logic [2:0] pos);
    logic [7:0] c;
    unique case (pos)
      3'd0:    c = 8'h74;
      3'd1:    c = 8'h69;
      3'd2:    c = 8'h6D;
      3'd3:    c = 8'h65;
      3'd4:    c = 8'h3D;
      3'd5:    c = 8'h30;
      default: c = 8'h78;
    endcase
    return c;
  endfunction

  // Lowercase hex digit of one nibble.
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] c;
    if (nib < 4'd10) begin
      c = 8'h30 + {4'h0, nib};
    end else begin
      c = 8'h57 + {4'h0, nib};
    end
    return c;
  endfunction

endpackage

// ===== rtl/core/scd_in_if.sv =====
// Input channel of the command decoder: received bytes and millisecond ticks.
interface scd_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] rx_byte;

  modport source (output valid, output action, output rx_byte, input ready);
  modport sink   (input valid, input action, input rx_byte, output ready);
endinterface

// ===== rtl/core/scd_out_if.sv =====
// Output channel of the command decoder: response beats and LED flags.
interface scd_out_if;
  logic       valid;
  logic       ready;
  logic       byte_valid;
  logic [7:0] tx_byte;
  logic       last;
  logic       yellow_led;
  logic       error_led;

  modport source (output valid, output byte_valid, output tx_byte, output last,
                  output yellow_led, output error_led, input ready);
  modport sink   (input valid, input byte_valid, input tx_byte, input last,
                  input yellow_led, input error_led, output ready);
endinterface

// ===== rtl/core/serial_command_decoder.sv =====
// Top level of the serial command decoder with millisecond time counter.
// The first result beat of an item is shown in the cycle after the item is accepted.
// Throughput: one beat per cycle while the sink is ready; an item with a single result beat can follow every cycle,
// a get sends 2 result beats and a time query 17, counted by the beat counter of the result register.
// Reset: flags and counter clear, the stored value becomes 0x3FFF, no result is pending.
module serial_command_decoder (
  input  logic      clk_i,
  input  logic      rst_ni,
  scd_in_if.sink    cmd_i,
  scd_out_if.source rsp_o
);

  logic        led_q, led_d;
  logic        err_q, err_d;
  logic [13:0] value_q, value_d;
  logic [1:0]  pend_q, pend_d;
  logic [6:0]  first_q, first_d;
  logic [31:0] ms_q, ms_d;

  logic                resp_valid_q;
  scd_pkg::resp_kind_e kind_q, kind_d;
  logic [4:0]          idx_q;

  logic       in_fire;
  logic       out_fire;
  logic       out_last;
  logic [2:0] nib_sel;
  logic [7:0] tx_byte;

  assign in_fire  = cmd_i.valid & cmd_i.ready;
  assign out_fire = resp_valid_q & rsp_o.ready;

  // A new item enters when the result register is empty or its final beat leaves now.
  assign cmd_i.ready = ~resp_valid_q | (rsp_o.ready & out_last);

  // Decode of one accepted item.
  always_comb begin
    led_d   = led_q;
    err_d   = err_q;
    value_d = value_q;
    pend_d  = pend_q;
    first_d = first_q;
    ms_d    = ms_q;
    kind_d  = scd_pkg::RESP_NONE;
    if (cmd_i.action) begin
      ms_d = ms_q + 32'd1;
    end else if (cmd_i.rx_byte[7]) begin
      // A command drops any pending data bytes and flags them as an error.
      if (pend_q != 2'd0) begin
        err_d = 1'b1;
      end
      pend_d = 2'd0;
      priority case (cmd_i.rx_byte)
        scd_pkg::CMD_TOGGLE: led_d  = ~led_q;
        scd_pkg::CMD_GET:    kind_d = scd_pkg::RESP_GET;
        scd_pkg::CMD_SET:    pend_d = 2'd2;
        scd_pkg::CMD_CLEAR:  err_d  = 1'b0;
        default:             err_d  = 1'b1;
      endcase
    end else if (pend_q != 2'd0) begin
      if (pend_q == 2'd1) begin
        value_d = {cmd_i.rx_byte[6:0], first_q};
        pend_d  = 2'd0;
      end else begin
        first_d = cmd_i.rx_byte[6:0];
        pend_d  = 2'd1;
      end
    end else if (cmd_i.rx_byte == scd_pkg::ASCII_TIME) begin
      kind_d = scd_pkg::RESP_TIME;
    end else if (cmd_i.rx_byte == scd_pkg::ASCII_LED) begin
      led_d = ~led_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      led_q   <= 1'b0;
      err_q   <= 1'b0;
      value_q <= scd_pkg::VALUE_RESET;
      pend_q  <= 2'd0;
      first_q <= 7'd0;
      ms_q    <= 32'd0;
    end else if (in_fire) begin
      led_q   <= led_d;
      err_q   <= err_d;
      value_q <= value_d;
      pend_q  <= pend_d;
      first_q <= first_d;
      ms_q    <= ms_d;
    end
  end

  // The state cannot change while a response is out, so beats read it directly.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      resp_valid_q <= 1'b0;
      kind_q       <= scd_pkg::RESP_NONE;
      idx_q        <= 5'd0;
    end else if (in_fire) begin
      resp_valid_q <= 1'b1;
      kind_q       <= kind_d;
      idx_q        <= 5'd0;
    end else if (out_fire) begin
      if (out_last) begin
        resp_valid_q <= 1'b0;
      end else begin
        idx_q <= idx_q + 5'd1;
      end
    end
  end

  // Digits run from the top nibble down.
  assign nib_sel = 3'(scd_pkg::TIME_DIGIT_TOP - idx_q);

  always_comb begin
    tx_byte  = 8'h00;
    out_last = 1'b1;
    unique case (kind_q)
      scd_pkg::RESP_GET: begin
        tx_byte  = idx_q[0] ? {2'b00, value_q[13:8]} : value_q[7:0];
        out_last = (idx_q == scd_pkg::GET_LAST_IDX);
      end
      scd_pkg::RESP_TIME: begin
        out_last = (idx_q == scd_pkg::TIME_LAST_IDX);
        priority if (idx_q < scd_pkg::TIME_DIGIT_FIRST) begin
          tx_byte = scd_pkg::prefix_char(idx_q[2:0]);
        end else if (idx_q < scd_pkg::TIME_CR_IDX) begin
          tx_byte = scd_pkg::hex_char(ms_q[{nib_sel, 2'b00} +: 4]);
        end else if (idx_q == scd_pkg::TIME_CR_IDX) begin
          tx_byte = scd_pkg::CHAR_CR;
        end else begin
          tx_byte = scd_pkg::CHAR_LF;
        end
      end
      default: begin
        tx_byte  = 8'h00;
        out_last = 1'b1;
      end
    endcase
  end

  assign rsp_o.valid      = resp_valid_q;
  assign rsp_o.byte_valid = (kind_q != scd_pkg::RESP_NONE);
  assign rsp_o.tx_byte    = tx_byte;
  assign rsp_o.last       = out_last;
  assign rsp_o.yellow_led = led_q;
  assign rsp_o.error_led  = err_q;

endmodule

// ===== rtl/core/scd_checker.sv =====
// Port-level assertions of the serial command decoder and their binding.
module scd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic       byte_valid_i,
  input logic [7:0] tx_byte_i,
  input logic       last_i,
  input logic       yellow_led_i,
  input logic       error_led_i
);

  // A stalled beat keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(tx_byte_i) && $stable(last_i))
    else $error("stalled result beat changed");

  // While a response is pending, a new item enters only when that response finishes in the same cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && out_valid_i |-> out_ready_i && last_i)
    else $error("item accepted while a response was still pending");

  // Every accepted item shows a result beat in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> out_valid_i)
    else $error("accepted item produced no result beat");

  // A beat without a response byte is the single, final result of its item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !byte_valid_i |-> last_i && (tx_byte_i == 8'h00))
    else $error("empty result beat is not a lone final beat");

  // The flags stay put between the beats of one response.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !last_i |=>
      $stable(yellow_led_i) && $stable(error_led_i))
    else $error("flags changed inside a response");

endmodule

bind serial_command_decoder scd_checker u_scd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (cmd_i.valid),
  .in_ready_i   (cmd_i.ready),
  .out_valid_i  (rsp_o.valid),
  .out_ready_i  (rsp_o.ready),
  .byte_valid_i (rsp_o.byte_valid),
  .tx_byte_i    (rsp_o.tx_byte),
  .last_i       (rsp_o.last),
  .yellow_led_i (rsp_o.yellow_led),
  .error_led_i  (rsp_o.error_led)
);

// ===== tb/sv/scd_tb_pkg.sv =====
// Reply beat type and the software mirror of the command decoder, used by its testbench.
package scd_tb_pkg;

  import scd_pkg::*;

  localparam logic [7:0] CMD_MARK       = 8'h80;
  localparam logic [7:0] CMD_UNKNOWN_LO = 8'h85;
  localparam logic [7:0] CMD_UNKNOWN_HI = 8'hFF;
  localparam logic [7:0] CH_ZERO        = "0";
  localparam logic [7:0] CH_LOWER_A     = "a";

  typedef struct packed {
    logic       byte_valid;
    logic [7:0] tx_byte;
    logic       last;
    logic       yellow_led;
    logic       error_led;
  } reply_beat_t;

  class decoder_mirror;
    logic        led_on;
    logic        err_on;
    logic [13:0] value;
    logic [1:0]  pend;
    logic [6:0]  first_byte;
    logic [31:0] ms_count;

    reply_beat_t replies[$];
    int unsigned mismatches;
    int unsigned beats_checked;
    int unsigned time_queries;
    int unsigned values_stored;

    function new();
      led_on     = 1'b0;
      err_on     = 1'b0;
      value      = VALUE_RESET;
      pend       = 2'd0;
      first_byte = 7'd0;
      ms_count   = 32'd0;
    endfunction

    // Works out the reply beats of one accepted item; returns 0 when the item is ignored.
    function bit take_item(input bit tick, input logic [7:0] b);
      logic [7:0] tx[$];
      logic [3:0] nib;
      bit         acted;
      string      prefix;
      acted  = 1'b1;
      prefix = "time=0x";
      if (tick) begin
        ms_count = ms_count + 32'd1;
      end else if (b[7]) begin
        // A command drops any data bytes still owed to a set, and flags it.
        if (pend != 2'd0) err_on = 1'b1;
        pend = 2'd0;
        case (b)
          CMD_TOGGLE: led_on = ~led_on;
          CMD_GET: begin
            tx.push_back(value[7:0]);
            tx.push_back({2'b00, value[13:8]});
          end
          CMD_SET:   pend = 2'd2;
          CMD_CLEAR: err_on = 1'b0;
          default:   err_on = 1'b1;
        endcase
      end else if (pend != 2'd0) begin
        if (pend == 2'd1) begin
          value = {b[6:0], first_byte};
          pend  = 2'd0;
          values_stored++;
        end else begin
          first_byte = b[6:0];
          pend       = 2'd1;
        end
      end else if (b == ASCII_TIME) begin
        time_queries++;
        for (int i = 0; i < prefix.len(); i++) tx.push_back(prefix[i]);
        for (int i = 7; i >= 0; i--) begin
          nib = ms_count[4*i +: 4];
          tx.push_back((nib < 4'd10) ? CH_ZERO + 8'(nib) : CH_LOWER_A + 8'(nib) - 8'd10);
        end
        tx.push_back(CHAR_CR);
        tx.push_back(CHAR_LF);
      end else if (b == ASCII_LED) begin
        led_on = ~led_on;
      end else begin
        acted = 1'b0;
      end

      if (tx.size() == 0) begin
        replies.push_back('{1'b0, 8'h00, 1'b1, led_on, err_on});
      end else begin
        foreach (tx[k]) replies.push_back('{1'b1, tx[k], k == tx.size() - 1, led_on, err_on});
      end
      return acted;
    endfunction

    task report_mismatch(input string msg);
      $display("mismatch: %s", msg);
      mismatches++;
    endtask

    task check_reply(input reply_beat_t got);
      reply_beat_t want;
      if (replies.size() == 0) begin
        report_mismatch($sformatf("beat 0x%0h arrived with nothing expected", got));
      end else begin
        want = replies.pop_front();
        if (got.byte_valid !== want.byte_valid)
          report_mismatch($sformatf("beat %0d byte_valid: expected %0b, got %0b",
                                    beats_checked, want.byte_valid, got.byte_valid));
        if (got.tx_byte !== want.tx_byte)
          report_mismatch($sformatf("beat %0d tx_byte: expected 0x%02h, got 0x%02h",
                                    beats_checked, want.tx_byte, got.tx_byte));
        if (got.last !== want.last)
          report_mismatch($sformatf("beat %0d last: expected %0b, got %0b",
                                    beats_checked, want.last, got.last));
        if (got.yellow_led !== want.yellow_led)
          report_mismatch($sformatf("beat %0d yellow_led: expected %0b, got %0b",
                                    beats_checked, want.yellow_led, got.yellow_led));
        if (got.error_led !== want.error_led)
          report_mismatch($sformatf("beat %0d error_led: expected %0b, got %0b",
                                    beats_checked, want.error_led, got.error_led));
      end
      beats_checked++;
    endtask

  endclass

endpackage

// ===== tb/sv/tb_serial_command_decoder.sv =====
// Testbench of the serial command decoder: directed and random byte and tick streams.
module tb_serial_command_decoder;

  import scd_pkg::*;
  import scd_tb_pkg::*;

  localparam int unsigned HALF_PERIOD   = 10;
  localparam int unsigned RESET_CYCLES  = 7;
  localparam int unsigned RANDOM_ITEMS  = 220;
  localparam int unsigned SETTLE_CYCLES = 20;
  localparam int unsigned CYCLE_LIMIT   = 200000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  bit          no_idle = 1'b0;
  int unsigned cycles = 0;
  int unsigned items_sent = 0;
  int unsigned effective_items = 0;

  decoder_mirror mirror = new();

  scd_in_if  cmd_if ();
  scd_out_if rsp_if ();

  serial_command_decoder dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cmd_i  (cmd_if),
    .rsp_o  (rsp_if)
  );

  always #(HALF_PERIOD) clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats outstanding", cycles, mirror.replies.size());
      $display("[serial_command_decoder] ERROR");
      $finish;
    end
  end

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_item(input bit tick, input logic [7:0] b);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd_if.valid   <= 1'b1;
    cmd_if.action  <= tick;
    cmd_if.rx_byte <= b;
    do @(posedge clk); while (cmd_if.ready !== 1'b1);
    if (mirror.take_item(tick, b)) effective_items++;
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_item(1'b0, b);
  endtask

  task automatic send_tick();
    send_item(1'b1, 8'($urandom));
  endtask

  task automatic wait_for_replies();
    cmd_if.valid <= 1'b0;
    while (mirror.replies.size() != 0) @(negedge clk);
  endtask

  initial begin : reply_sink
    int unsigned stall;
    reply_beat_t got;
    rsp_if.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 3);
      if (stall != 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk); while (rsp_if.valid !== 1'b1);
      got = '{byte_valid: rsp_if.byte_valid, tx_byte: rsp_if.tx_byte, last: rsp_if.last,
              yellow_led: rsp_if.yellow_led, error_led: rsp_if.error_led};
      mirror.check_reply(got);
      @(negedge clk);
    end
  end

  initial begin : stimulus
    int unsigned pick;
    int unsigned picks;
    int unsigned goal;
    cmd_if.valid   = 1'b0;
    cmd_if.action  = 1'b0;
    cmd_if.rx_byte = 8'h00;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part: field extremes, every command, and the error paths.
    send_item(1'b1, 8'hFF);
    send_byte(ASCII_TIME);
    send_byte(CMD_GET);
    send_byte(CMD_SET);
    send_byte(8'h7F);
    send_byte(8'h00);
    send_byte(CMD_GET);
    send_byte(CMD_SET);
    send_byte(8'h00);
    send_byte(8'h7F);
    send_byte(CMD_GET);
    send_byte(ASCII_LED);
    send_byte(CMD_TOGGLE);
    send_byte(CMD_MARK);
    send_byte(CMD_CLEAR);
    // A command that cuts a set short raises the error flag and still runs.
    send_byte(CMD_SET);
    send_byte(CMD_TOGGLE);
    send_byte(CMD_CLEAR);
    send_byte(CMD_SET);
    send_byte(8'h12);
    send_byte(CMD_GET);
    send_byte(CMD_UNKNOWN_HI);
    send_byte(CMD_UNKNOWN_LO);
    send_byte(CMD_CLEAR);
    send_byte(8'h54);
    send_byte(8'h00);
    wait_for_replies();

    // Random part: mostly well-formed commands with random data, some noise.
    goal  = effective_items + RANDOM_ITEMS;
    picks = 0;
    while (effective_items < goal) begin
      picks++;
      if (picks == 40) wait_for_replies();
      no_idle = (picks >= 70 && picks < 100);
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        send_byte(CMD_SET);
        send_byte({1'b0, 7'($urandom)});
        send_byte({1'b0, 7'($urandom)});
        if ($urandom_range(0, 1) != 0) send_byte(CMD_GET);
      end else if (pick < 42) begin
        send_byte(CMD_GET);
      end else if (pick < 57) begin
        repeat ($urandom_range(1, 4)) send_tick();
      end else if (pick < 65) begin
        send_byte(ASCII_TIME);
      end else if (pick < 71) begin
        send_byte(($urandom_range(0, 1) != 0) ? CMD_TOGGLE : ASCII_LED);
      end else if (pick < 76) begin
        send_byte(CMD_CLEAR);
      end else if (pick < 84) begin
        send_byte(CMD_SET);
        if ($urandom_range(0, 1) != 0) send_byte({1'b0, 7'($urandom)});
        send_byte({1'b1, 7'($urandom)});
      end else begin
        send_byte(8'($urandom));
      end
    end
    no_idle = 1'b0;

    wait_for_replies();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mirror.replies.size() != 0)
      mirror.report_mismatch($sformatf("%0d beats never arrived", mirror.replies.size()));

    $display("Sent %0d items (%0d not ignored), checked %0d reply beats.",
             items_sent, effective_items, mirror.beats_checked);
    $display("Covered %0d time queries, %0d stored values, counter ended at %0d.",
             mirror.time_queries, mirror.values_stored, mirror.ms_count);
    if (mirror.mismatches == 0) begin
      $display("[serial_command_decoder] OK");
    end else begin
      $display("[serial_command_decoder] ERROR");
    end
    $finish;
  end

endmodule
